// ===== rtl/ssw_pkg.sv =====
// Shared types, constants and divisor tables of the sine-square waveshaper.
package ssw_pkg;

	localparam int SAMPLE_W = 24;
	localparam int QUO_W    = 23;
	localparam int HRN_STEPS = 8;
	localparam int DIV_STAGES = QUO_W;
	// cycles from the accepting edge to the edge that takes the result word
	localparam int LATENCY = 56;

	// 1/(2*pi) in Q64, split in 32-bit halves
	localparam logic [31:0] K_LO = 32'h9391054A;
	localparam logic [29:0] K_HI = 30'h28BE60DB;
	// pi/2 in Q32
	localparam logic [32:0] HALF_PI_Q32 = 33'h1921FB544;

	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
	localparam logic [32:0] ONE_Q31 = 33'h0_8000_0000;

	// series kind and scale of one Horner pass
	typedef enum logic [1:0] {
		MODE_SINC32 = 2'd0,
		MODE_SINC31 = 2'd1,
		MODE_COS31  = 2'd2
	} hmode_t;

	// divisors per step; the sinc series has one step less, so its first entry is unused
	localparam logic [7:0] SINC_DIV [HRN_STEPS] = '{8'd2, 8'd210, 8'd156, 8'd110,
		8'd72, 8'd42, 8'd20, 8'd6};
	localparam logic [7:0] COS_DIV [HRN_STEPS] = '{8'd240, 8'd182, 8'd132, 8'd90,
		8'd56, 8'd30, 8'd12, 8'd2};
	// floor(2^36 / divisor)
	localparam logic [35:0] SINC_RCP [HRN_STEPS] = '{36'd34359738368, 36'd327235603,
		36'd440509466, 36'd624722515, 36'd954437176, 36'd1636178017,
		36'd3435973836, 36'd11453246122};
	localparam logic [35:0] COS_RCP [HRN_STEPS] = '{36'd286331153, 36'd377579542,
		36'd520602096, 36'd763549741, 36'd1227133513, 36'd2290649224,
		36'd5726623061, 36'd34359738368};

	typedef struct packed {
		logic [23:0] a;
		logic        neg;
		logic [1:0]  quad;
		logic [31:0] z;
	} side_t;

	// one Horner step word: x holds r, then the scaled product
	typedef struct packed {
		logic [32:0] u;
		logic [32:0] x;
		logic [32:0] q;
		hmode_t      mode;
		side_t       side;
	} hrn_t;

	// restoring divider word
	typedef struct packed {
		logic [44:0]      rem;
		logic [QUO_W-1:0] q;
		logic [23:0]      a;
		logic             neg_out;
		logic             low_path;
		logic [22:0]      m_small;
	} dv_t;

	function automatic logic [7:0] hrn_div(input logic [2:0] k, input logic cos);
		return cos ? COS_DIV[k] : SINC_DIV[k];
	endfunction

	function automatic logic [35:0] hrn_recip(input logic [2:0] k, input logic cos);
		return cos ? COS_RCP[k] : SINC_RCP[k];
	endfunction

endpackage

// ===== rtl/ssw_chan.sv =====
// One channel of the waveshaper: sin(x*|x|)/|x| as a deep pipeline.
module ssw_chan import ssw_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic                       out_valid,
	output logic signed [SAMPLE_W-1:0] shaped
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s31, v_s32, v_s56;
	logic [HRN_STEPS-1:0]  vra_s, vrb_s, vrc_s;
	logic [DIV_STAGES-1:0] vd_s;

	logic [23:0]  a_s1, a_s2, a_s3, a_s4, a_s5;
	logic         neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [46:0]  y_s2;
	logic [63:0]  ll_s3;
	logic [61:0]  lh_s3;
	logic [46:0]  hl_s3;
	logic [44:0]  hh_s3;
	logic [31:0]  y32_s3;
	logic [31:0]  ph_s4, us_s4, us_s5, z_s5;
	logic [1:0]   quad_s5;
	hrn_t         h_s6, h6_c;
	hrn_t         hrn_in [HRN_STEPS];
	hrn_t         hra_s [HRN_STEPS];
	hrn_t         hrb_s [HRN_STEPS];
	hrn_t         hrc_s [HRN_STEPS];
	hrn_t         hend;
	logic [56:0]  mp_s31;
	logic [31:0]  sl_s31;
	side_t        sd_s31;
	logic         small_s31;
	dv_t          dv_s32;
	dv_t          dv_in [DIV_STAGES];
	dv_t          dvr_s [DIV_STAGES];
	logic [SAMPLE_W-1:0] res_s56;

	logic [23:0]  mag_c;
	logic [109:0] psum_c;
	logic [63:0]  usq_c, zz_c, zh_c;
	logic [62:0]  zp_c;
	logic [57:0]  msum_c;
	logic [23:0]  m_c;
	dv_t          dend;

	// magnitude; the most negative code maps to 2^23 exactly
	assign mag_c = sample[SAMPLE_W-1] ? (~sample + 24'd1) : sample;

	// front valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// square, phase partial products, phase sum, angle, series argument
	assign psum_c = {46'd0, ll_s3} + {16'd0, lh_s3, 32'd0} + {31'd0, hl_s3, 32'd0}
		+ {1'd0, hh_s3, 64'd0};
	assign usq_c  = {32'd0, y32_s3} * {32'd0, y32_s3};
	assign zp_c   = {33'd0, ph_s4[29:0]} * {30'd0, HALF_PI_Q32};
	assign zz_c   = {32'd0, z_s5} * {32'd0, z_s5};

	always_ff @(posedge clk) begin
		a_s1   <= mag_c;
		neg_s1 <= sample[SAMPLE_W-1];
		y_s2   <= 47'({24'd0, a_s1} * {24'd0, a_s1});
		a_s2   <= a_s1;
		neg_s2 <= neg_s1;
		ll_s3  <= {32'd0, y_s2[31:0]} * {32'd0, K_LO};
		lh_s3  <= {30'd0, y_s2[31:0]} * {32'd0, K_HI};
		hl_s3  <= {32'd0, y_s2[46:32]} * {15'd0, K_LO};
		hh_s3  <= {30'd0, y_s2[46:32]} * {15'd0, K_HI};
		y32_s3 <= y_s2[43:12];
		a_s3   <= a_s2;
		neg_s3 <= neg_s2;
		ph_s4  <= psum_c[107:76];
		us_s4  <= usq_c[63:32];
		a_s4   <= a_s3;
		neg_s4 <= neg_s3;
		z_s5    <= zp_c[62:31];
		quad_s5 <= ph_s4[31:30];
		us_s5   <= us_s4;
		a_s5    <= a_s4;
		neg_s5  <= neg_s4;
		h_s6    <= h6_c;
	end

	// pick the series for the item: small inputs take sinc in Q32
	always_comb begin
		h6_c.side.a    = a_s5;
		h6_c.side.neg  = neg_s5;
		h6_c.side.quad = quad_s5;
		h6_c.side.z    = z_s5;
		h6_c.q         = '0;
		if (a_s5[23:22] == 2'b00) begin
			h6_c.mode = MODE_SINC32;
			h6_c.u    = {1'b0, us_s5};
			h6_c.x    = ONE_Q32;
		end else begin
			h6_c.mode = quad_s5[0] ? MODE_COS31 : MODE_SINC31;
			h6_c.u    = zz_c[63:31];
			h6_c.x    = ONE_Q31;
		end
	end

	// Horner steps, three stages each: product, reciprocal, correction
	genvar k;
	generate
		for (k = 0; k < HRN_STEPS; k++) begin : g_hrn
			logic        vin;
			logic [65:0] prod_c;
			logic [68:0] qp_c;
			logic [40:0] qd_c;
			logic [32:0] rem_c, t_c, one_c, r_c;
			logic [7:0]  d_c;
			logic        cos_b, cos_c;
			hrn_t        a_nx_c, b_nx_c, c_nx_c;

			if (k == 0) begin : g_first
				assign hrn_in[k] = h_s6;
				assign vin       = v_s6;
			end else begin : g_next
				assign hrn_in[k] = hrc_s[k-1];
				assign vin       = vrc_s[k-1];
			end

			assign prod_c = {33'd0, hrn_in[k].u} * {33'd0, hrn_in[k].x};
			assign cos_b  = (hra_s[k].mode == MODE_COS31);
			assign qp_c   = {36'd0, hra_s[k].x} * {33'd0, hrn_recip(3'(k), cos_b)};
			assign cos_c  = (hrb_s[k].mode == MODE_COS31);
			assign d_c    = hrn_div(3'(k), cos_c);
			assign qd_c   = {8'd0, hrb_s[k].q} * {33'd0, d_c};
			assign rem_c  = hrb_s[k].x - qd_c[32:0];
			assign t_c    = (rem_c >= {25'd0, d_c}) ? (hrb_s[k].q + 33'd1) : hrb_s[k].q;
			assign one_c  = (hrb_s[k].mode == MODE_SINC32) ? ONE_Q32 : ONE_Q31;

			// the sinc series skips the first step; clamp at zero
			always_comb begin
				if ((k == 0) && !cos_c)
					r_c = one_c;
				else if (t_c >= one_c)
					r_c = '0;
				else
					r_c = one_c - t_c;
			end

			// next stage words
			always_comb begin
				a_nx_c   = hrn_in[k];
				a_nx_c.x = (hrn_in[k].mode == MODE_SINC32) ? prod_c[64:32] : prod_c[63:31];
				b_nx_c   = hra_s[k];
				b_nx_c.q = qp_c[68:36];
				c_nx_c   = hrb_s[k];
				c_nx_c.x = r_c;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vra_s[k] <= 1'b0;
					vrb_s[k] <= 1'b0;
					vrc_s[k] <= 1'b0;
				end else begin
					vra_s[k] <= vin;
					vrb_s[k] <= vra_s[k];
					vrc_s[k] <= vrb_s[k];
				end
			end

			always_ff @(posedge clk) begin
				hra_s[k] <= a_nx_c;
				hrb_s[k] <= b_nx_c;
				hrc_s[k] <= c_nx_c;
			end
		end
	endgenerate

	assign hend = hrc_s[HRN_STEPS-1];

	// scale by x on the small path, form the sine on the large one
	assign zh_c   = {32'd0, hend.side.z} * {32'd0, hend.x[31:0]};
	assign msum_c = {1'b0, mp_s31} + 58'h0_0000_8000_0000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s31 <= 1'b0;
			v_s32 <= 1'b0;
		end else begin
			v_s31 <= vrc_s[HRN_STEPS-1];
			v_s32 <= v_s31;
		end
	end

	always_ff @(posedge clk) begin
		mp_s31    <= {33'd0, hend.side.a} * {24'd0, hend.x};
		sl_s31    <= hend.side.quad[0] ? hend.x[31:0] : zh_c[62:31];
		sd_s31    <= hend.side;
		small_s31 <= (hend.mode == MODE_SINC32);
		// dividend carries half the divisor for round half up
		dv_s32.rem      <= {sl_s31, 13'd0} + {22'd0, sd_s31.a[23:1]};
		dv_s32.q        <= '0;
		dv_s32.a        <= sd_s31.a;
		dv_s32.neg_out  <= sd_s31.neg ^ (!small_s31 & sd_s31.quad[1]);
		dv_s32.low_path <= small_s31;
		dv_s32.m_small  <= msum_c[54:32];
	end

	// restoring divider, one quotient bit per stage
	genvar i;
	generate
		for (i = 0; i < DIV_STAGES; i++) begin : g_div
			logic [45:0] dsh_c;
			logic        ge_c;
			logic        vin;
			dv_t         nx_c;

			if (i == 0) begin : g_first
				assign dv_in[i] = dv_s32;
				assign vin      = v_s32;
			end else begin : g_next
				assign dv_in[i] = dvr_s[i-1];
				assign vin      = vd_s[i-1];
			end

			assign dsh_c = {22'd0, dv_in[i].a} << (QUO_W - 1 - i);
			assign ge_c  = ({1'b0, dv_in[i].rem} >= dsh_c);

			always_comb begin
				nx_c = dv_in[i];
				if (ge_c)
					nx_c.rem = 45'({1'b0, dv_in[i].rem} - dsh_c);
				nx_c.q[QUO_W-1-i] = ge_c;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vd_s[i] <= 1'b0;
				else
					vd_s[i] <= vin;
			end

			always_ff @(posedge clk) begin
				dvr_s[i] <= nx_c;
			end
		end
	endgenerate

	// pick the path, apply the sign
	assign dend = dvr_s[DIV_STAGES-1];
	assign m_c  = {1'b0, dend.low_path ? dend.m_small : dend.q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s56 <= 1'b0;
		else
			v_s56 <= vd_s[DIV_STAGES-1];
	end

	always_ff @(posedge clk) begin
		res_s56 <= dend.neg_out ? (~m_c + 24'd1) : m_c;
	end

	assign out_valid = v_s56;
	assign shaped    = res_s56;

endmodule

// ===== rtl/sine_square_waveshaper_top.sv =====
// Top level of the stereo sine-square waveshaper: two channel pipelines.
// Pipeline: 56 register stages, mostly the eight Horner steps and the 23-stage
// restoring divider; a word accepted with start is strobed on done when its
// result leaves the last stage.
// Throughput: one stereo word per cycle; busy stays low.
// Reset: arst_n clears all valid bits at once; data registers are not reset.
module sine_square_waveshaper_top import ssw_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [SAMPLE_W-1:0] sample_left,
	input  logic signed [SAMPLE_W-1:0] sample_right,
	output logic                       done,
	output logic signed [SAMPLE_W-1:0] shaped_left,
	output logic signed [SAMPLE_W-1:0] shaped_right
);

	logic valid_l, valid_r;

	// fully pipelined, never stalls
	assign busy = 1'b0;

	ssw_chan u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.sample    (sample_left),
		.out_valid (valid_l),
		.shaped    (shaped_left)
	);

	ssw_chan u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start),
		.sample    (sample_right),
		.out_valid (valid_r),
		.shaped    (shaped_right)
	);

	assign done = valid_l;

	// both channels deliver together
	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		valid_l == valid_r)
		else $error("channel valid bits out of step");

	// every result traces back to an accepted word
	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result word without an accepted input");

	// zero in gives zero out
	a_zero_left: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(start && (sample_left == '0), LATENCY)) |-> (shaped_left == '0))
		else $error("nonzero result for zero left input");

endmodule
